### rtl/hevc_sps_picture_size_parser_macros.svh
// Assertion helpers for the SPS picture size parser
`ifndef HEVC_SPS_PICTURE_SIZE_PARSER_MACROS_SVH
`define HEVC_SPS_PICTURE_SIZE_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define HSPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hsps assertion failed");

// Next-cycle implication, checked outside reset
`define HSPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hsps assertion failed");

`endif

### rtl/hsps_pkg.sv
// ----------------------------------------------------------------------------
// hsps_pkg
// Shared types and constants of the SPS picture size parser.
// ----------------------------------------------------------------------------
package hsps_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_RAN_OUT = 2'd1;
  localparam logic [1:0] STATUS_BAD_UE  = 2'd2;
  localparam logic [1:0] STATUS_CROP    = 2'd3;

  // One classified byte in the queue between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       keep;
  } q_entry_t;

  // Push side of the queue
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  // Pop side status of the queue
  typedef struct packed {
    logic     empty;
    q_entry_t head;
  } q_head_t;

endpackage

### rtl/hsps_front.sv
// ----------------------------------------------------------------------------
// hsps_front
// Accepts raw bytes and marks emulation-prevention bytes for dropping.
// ----------------------------------------------------------------------------
module hsps_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             last_i,
  input  logic             q_full_i,
  output hsps_pkg::q_push_t q_push_o
);

  logic [1:0] zero_run_q, zero_run_d;
  logic       accept;
  logic       escape;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign escape     = (zero_run_q == 2'd2) && (data_byte_i == 8'h03);

  // Classify the item and push it
  always_comb begin
    q_push_o.push       = accept;
    q_push_o.entry.data = data_byte_i;
    q_push_o.entry.last = last_i;
    q_push_o.entry.keep = ~escape;
  end

  // Track the run of zero bytes; a dropped escape clears it
  always_comb begin
    zero_run_d = zero_run_q;
    if (accept) begin
      if (escape || data_byte_i != 8'h00) begin
        zero_run_d = 2'd0;
      end else if (zero_run_q != 2'd2) begin
        zero_run_d = zero_run_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q <= 2'd0;
    end else begin
      zero_run_q <= zero_run_d;
    end
  end

endmodule

### rtl/hsps_queue.sv
// ----------------------------------------------------------------------------
// hsps_queue
// Two-entry queue that decouples byte intake from the bit-serial parser.
// ----------------------------------------------------------------------------
module hsps_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsps_pkg::q_push_t q_push_i,
  input  logic              pop_i,
  output logic              full_o,
  output hsps_pkg::q_head_t q_head_o
);

  hsps_pkg::q_entry_t slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o         = (cnt_q == 2'd2);
  assign do_push        = q_push_i.push & ~full_o;
  assign do_pop         = pop_i & (cnt_q != 2'd0);
  assign q_head_o.empty = (cnt_q == 2'd0);
  assign q_head_o.head  = slot_q[rd_q];

  // Count entries
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= q_push_i.entry;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
    end
  end

endmodule

### rtl/hsps_back.sv
// ----------------------------------------------------------------------------
// hsps_back
// Bit-serial SPS field walker and result stage.
// ----------------------------------------------------------------------------
module hsps_back #(
  parameter int MAX_SUB_LAYERS = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsps_pkg::q_head_t q_head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [31:0]       pic_width_o,
  output logic [31:0]       pic_height_o
);

  localparam int FW = 2 * MAX_SUB_LAYERS;

  typedef enum logic [4:0] {
    ST_SKIP_HDR, ST_READ_SUBL, ST_SKIP_PTL, ST_FLAGS, ST_RESERVED,
    ST_SL_PROFILE, ST_SL_LEVEL, ST_UE_ID, ST_UE_CHROMA, ST_SEP_COLOUR,
    ST_UE_WIDTH, ST_UE_HEIGHT, ST_WIN_FLAG, ST_UE_LEFT, ST_UE_RIGHT,
    ST_UE_TOP, ST_UE_BOTTOM, ST_DONE
  } step_e;

  typedef enum logic [1:0] {PH_IDLE, PH_BITS, PH_FIN} phase_e;

  phase_e             phase_q, phase_d;
  hsps_pkg::q_entry_t ent_q, ent_d;
  logic [2:0]         bit_q, bit_d;
  logic               pend_q, pend_d;
  step_e              step_q, step_d;
  logic [6:0]         bits_q, bits_d;
  logic [31:0]        val_q, val_d;
  logic [5:0]         gz_q, gz_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [2:0]         idx_q, idx_d;
  logic [FW-1:0]      flags_q, flags_d;
  logic [31:0]        chroma_q, chroma_d;
  logic [31:0]        cw_q, cw_d, ch_q, ch_d;
  logic [32:0]        crop0_q, crop0_d, crop1_q, crop1_d;
  logic               done_q, done_d;
  logic [1:0]         err_q, err_d;
  logic               ov_q, ov_d;
  logic [1:0]         st_q, st_d;
  logic [31:0]        w_q, w_d, h_q, h_d;

  logic        b, is_ue, go, prof_flag, lvl_flag, fin_done, sw2, sh2, out_free;
  step_e       nxt;
  logic [31:0] val_new, ue_v;
  logic [3:0]  pos;
  logic [33:0] cw34, ch34;

  assign out_valid_o  = ov_q;
  assign status_o     = st_q;
  assign pic_width_o  = w_q;
  assign pic_height_o = h_q;
  assign out_free     = ~ov_q | ~out_stall_i;

  assign b       = ent_q.data[3'd7 - bit_q];
  assign val_new = {val_q[30:0], b};
  // A code with no leading zeros ends in the prefix and is worth zero
  assign ue_v    = (bits_q == 7'd0) ? 32'd0 :
                   (((32'd1 << gz_q[4:0]) - 32'd1) + val_new);
  assign pos     = {cnt_q, 1'b0} - bits_q[3:0];
  assign is_ue   = (step_q == ST_UE_ID) || (step_q == ST_UE_CHROMA) ||
                   (step_q == ST_UE_WIDTH) || (step_q == ST_UE_HEIGHT) ||
                   (step_q == ST_UE_LEFT) || (step_q == ST_UE_RIGHT) ||
                   (step_q == ST_UE_TOP) || (step_q == ST_UE_BOTTOM);

  // Look up the present flags of the current sub-layer
  always_comb begin
    prof_flag = 1'b0;
    lvl_flag  = 1'b0;
    for (int k = 0; k < MAX_SUB_LAYERS; k++) begin
      if (idx_q == 3'(k)) begin
        prof_flag = flags_q[2*k];
        lvl_flag  = flags_q[2*k+1];
      end
    end
  end

  // Final size computation
  assign fin_done = done_q | (pend_q & (step_q == ST_DONE));
  assign sw2      = (chroma_q == 32'd1) || (chroma_q == 32'd2);
  assign sh2      = (chroma_q == 32'd1);
  assign cw34     = sw2 ? {crop0_q, 1'b0} : {1'b0, crop0_q};
  assign ch34     = sh2 ? {crop1_q, 1'b0} : {1'b0, crop1_q};

  always_comb begin
    phase_d = phase_q; ent_d = ent_q; bit_d = bit_q; pend_d = pend_q;
    step_d = step_q; bits_d = bits_q; val_d = val_q; gz_d = gz_q;
    cnt_d = cnt_q; idx_d = idx_q; flags_d = flags_q; chroma_d = chroma_q;
    cw_d = cw_q; ch_d = ch_q; crop0_d = crop0_q; crop1_d = crop1_q;
    done_d = done_q; err_d = err_q; ov_d = ov_q; st_d = st_q;
    w_d = w_q; h_d = h_q;
    pop_o = 1'b0;
    go    = 1'b0;
    nxt   = step_q;

    // Drop the result once taken
    if (ov_q && !out_stall_i) ov_d = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        if (!q_head_i.empty) begin
          pop_o   = 1'b1;
          ent_d   = q_head_i.head;
          bit_d   = 3'd0;
          phase_d = PH_BITS;
        end
      end
      PH_BITS: begin
        if (!ent_q.keep || done_q || err_q != 2'd0) begin
          phase_d = ent_q.last ? PH_FIN : PH_IDLE;
        end else if (pend_q) begin
          // Set up the field just entered, or skip past it
          pend_d = 1'b0;
          case (step_q)
            ST_SKIP_HDR:  bits_d = 7'd20;
            ST_READ_SUBL: bits_d = 7'd3;
            ST_SKIP_PTL:  bits_d = 7'd97;
            ST_FLAGS: begin
              if (cnt_q == 3'd0) begin
                step_d = ST_UE_ID; pend_d = 1'b1;
              end else begin
                flags_d = '0;
                bits_d  = {3'd0, cnt_q, 1'b0};
              end
            end
            ST_RESERVED: bits_d = {3'd0, 3'(4'd8 - {1'b0, cnt_q}), 1'b0};
            ST_SL_PROFILE: begin
              pend_d = 1'b1;
              if (idx_q >= cnt_q) step_d = ST_UE_ID;
              else if (prof_flag) begin
                bits_d = 7'd88; pend_d = 1'b0;
              end else step_d = ST_SL_LEVEL;
            end
            ST_SL_LEVEL: begin
              if (lvl_flag) bits_d = 7'd8;
              else begin
                idx_d = idx_q + 3'd1; step_d = ST_SL_PROFILE; pend_d = 1'b1;
              end
            end
            ST_SEP_COLOUR: begin
              if (chroma_q == 32'd3) bits_d = 7'd1;
              else begin
                step_d = ST_UE_WIDTH; pend_d = 1'b1;
              end
            end
            ST_WIN_FLAG: bits_d = 7'd1;
            ST_DONE:     done_d = 1'b1;
            default:     bits_d = 7'd0;
          endcase
        end else begin
          // Consume one bit
          bit_d = bit_q + 3'd1;
          if (bit_q == 3'd7) phase_d = ent_q.last ? PH_FIN : PH_IDLE;
          if (is_ue) begin
            if (bits_q == 7'd0) begin
              if (!b) begin
                gz_d = gz_q + 6'd1;
                if (gz_q == 6'd31) err_d = hsps_pkg::STATUS_BAD_UE;
              end else if (gz_q == 6'd0) begin
                go = 1'b1;
              end else begin
                bits_d = {1'b0, gz_q};
                val_d  = '0;
              end
            end else begin
              val_d  = val_new;
              bits_d = bits_q - 7'd1;
              if (bits_q == 7'd1) go = 1'b1;
            end
            if (go) begin
              case (step_q)
                ST_UE_ID:     nxt = ST_UE_CHROMA;
                ST_UE_CHROMA: begin chroma_d = ue_v; nxt = ST_SEP_COLOUR; end
                ST_UE_WIDTH:  begin cw_d = ue_v; nxt = ST_UE_HEIGHT; end
                ST_UE_HEIGHT: begin ch_d = ue_v; nxt = ST_WIN_FLAG; end
                ST_UE_LEFT:   begin crop0_d = {1'b0, ue_v}; nxt = ST_UE_RIGHT; end
                ST_UE_RIGHT:  begin crop0_d = crop0_q + {1'b0, ue_v}; nxt = ST_UE_TOP; end
                ST_UE_TOP:    begin crop1_d = {1'b0, ue_v}; nxt = ST_UE_BOTTOM; end
                default:      begin crop1_d = crop1_q + {1'b0, ue_v}; nxt = ST_DONE; end
              endcase
            end
          end else begin
            if (step_q == ST_FLAGS && b) begin
              for (int k = 0; k < FW; k++) begin
                if (pos == 4'(k)) flags_d[k] = 1'b1;
              end
            end
            val_d = val_new;
            if (bits_q != 7'd0) bits_d = bits_q - 7'd1;
            if (bits_q <= 7'd1) begin
              go = 1'b1;
              case (step_q)
                ST_SKIP_HDR: nxt = ST_READ_SUBL;
                ST_READ_SUBL: begin
                  cnt_d = val_new[2:0];
                  if (32'(val_new[2:0]) > 32'(MAX_SUB_LAYERS)) begin
                    err_d = hsps_pkg::STATUS_BAD_UE; go = 1'b0;
                  end
                  nxt = ST_SKIP_PTL;
                end
                ST_SKIP_PTL:   nxt = ST_FLAGS;
                ST_FLAGS:      nxt = ST_RESERVED;
                ST_RESERVED:   begin idx_d = 3'd0; nxt = ST_SL_PROFILE; end
                ST_SL_PROFILE: nxt = ST_SL_LEVEL;
                ST_SL_LEVEL:   begin idx_d = idx_q + 3'd1; nxt = ST_SL_PROFILE; end
                ST_SEP_COLOUR: nxt = ST_UE_WIDTH;
                default:       nxt = (val_new != 32'd0) ? ST_UE_LEFT : ST_DONE;
              endcase
            end
          end
          if (go) begin
            step_d = nxt; val_d = '0; gz_d = '0; bits_d = '0; pend_d = 1'b1;
          end
        end
      end
      PH_FIN: begin
        if (out_free) begin
          // Load the result and restart for the next unit
          ov_d = 1'b1;
          w_d  = '0;
          h_d  = '0;
          if (err_q != 2'd0) st_d = err_q;
          else if (!fin_done) st_d = hsps_pkg::STATUS_RAN_OUT;
          else if ({2'b0, cw_q} <= cw34 || {2'b0, ch_q} <= ch34) st_d = hsps_pkg::STATUS_CROP;
          else begin
            st_d = hsps_pkg::STATUS_OK;
            w_d  = cw_q - cw34[31:0];
            h_d  = ch_q - ch34[31:0];
          end
          phase_d = PH_IDLE;
          step_d = ST_SKIP_HDR; pend_d = 1'b1; bits_d = '0; val_d = '0; gz_d = '0;
          cnt_d = '0; idx_d = '0; flags_d = '0; chroma_d = '0; cw_d = '0; ch_d = '0;
          crop0_d = '0; crop1_d = '0; done_d = 1'b0; err_d = '0;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    st_q  <= st_d;
    w_q   <= w_d;
    h_q   <= h_d;
  end

  // Parser state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; bit_q <= '0; pend_q <= 1'b1; step_q <= ST_SKIP_HDR;
      bits_q <= '0; val_q <= '0; gz_q <= '0; cnt_q <= '0; idx_q <= '0;
      flags_q <= '0; chroma_q <= '0; cw_q <= '0; ch_q <= '0;
      crop0_q <= '0; crop1_q <= '0; done_q <= 1'b0; err_q <= '0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; bit_q <= bit_d; pend_q <= pend_d; step_q <= step_d;
      bits_q <= bits_d; val_q <= val_d; gz_q <= gz_d; cnt_q <= cnt_d; idx_q <= idx_d;
      flags_q <= flags_d; chroma_q <= chroma_d; cw_q <= cw_d; ch_q <= ch_d;
      crop0_q <= crop0_d; crop1_q <= crop1_d; done_q <= done_d; err_q <= err_d;
      ov_q <= ov_d;
    end
  end

endmodule

### rtl/hevc_sps_picture_size_parser.sv
// Takes one byte of an HEVC SPS NAL unit per item and, on the byte marked last,
// gives one result: status and the cropped picture size. Bytes enter a
// two-entry queue unless it is full; the parser behind it walks each kept byte
// one bit per clock, pausing at each field boundary, and passes over a dropped
// escape byte or a byte after parsing ends without walking its bits; the last
// byte also forms the result.
// ----------------------------------------------------------------------------
// hevc_sps_picture_size_parser
// Top level: byte front end, queue and bit-serial SPS parser.
// ----------------------------------------------------------------------------
`include "hevc_sps_picture_size_parser_macros.svh"

module hevc_sps_picture_size_parser #(
  parameter int MAX_SUB_LAYERS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] pic_width_o,
  output logic [31:0] pic_height_o
);

  hsps_pkg::q_push_t q_push;
  hsps_pkg::q_head_t q_head;
  logic              q_full;
  logic              q_pop;

  hsps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push)
  );

  hsps_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_push_i (q_push),
    .pop_i    (q_pop),
    .full_o   (q_full),
    .q_head_o (q_head)
  );

  hsps_back #(
    .MAX_SUB_LAYERS (MAX_SUB_LAYERS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_head_i     (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .pic_width_o  (pic_width_o),
    .pic_height_o (pic_height_o)
  );

  // An ok result always has a picture left after cropping
  `HSPS_ASSERT_IMP(a_ok_nonzero, clk_i, rst_ni, out_valid_o && status_o == hsps_pkg::STATUS_OK, pic_width_o != 32'd0 && pic_height_o != 32'd0)
  // An error result carries a zero size
  `HSPS_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && status_o != hsps_pkg::STATUS_OK, pic_width_o == 32'd0 && pic_height_o == 32'd0)
  // The queue never pushes while full
  `HSPS_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, q_full, !q_push.push)

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPS picture size parser testbench
// Builds HEVC SPS NAL units bit by bit, escapes them and feeds them in one byte
// per item. A model of the bit walk in this file works out each result, and a
// checker compares every result, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_SUB_LAYERS = 7;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum logic [4:0] {
    FS_HDR, FS_SUBL, FS_PTL, FS_FLAGS, FS_RSVD, FS_SL_PROF, FS_SL_LVL, FS_UE_ID,
    FS_UE_CHROMA, FS_SEP, FS_UE_W, FS_UE_H, FS_WIN, FS_UE_L, FS_UE_R, FS_UE_T,
    FS_UE_B, FS_DONE
  } field_e;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] width;
    logic [31:0] height;
  } pic_size_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] pic_width_o;
  logic [31:0] pic_height_o;

  pic_size_t size_q[$];
  bit        bit_q[$];
  int        errors = 0;
  int        sizes_seen = 0;
  int        bytes_sent = 0;
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;
  int        quiet_cycles = 0;

  hevc_sps_picture_size_parser #(.MAX_SUB_LAYERS(MAX_SUB_LAYERS)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .data_byte_i(data_byte_i), .last_i(last_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .status_o(status_o), .pic_width_o(pic_width_o), .pic_height_o(pic_height_o)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------- parse model ----------------
  int          p_zrun, p_left, p_gzc, p_nsub, p_sidx;
  field_e      p_step;
  logic [31:0] p_val, p_chroma;
  logic [13:0] p_flags;
  logic [31:0] p_coded[2];
  logic [32:0] p_crop[2];
  bit          p_done;
  logic [1:0]  p_err;

  function automatic bit is_ue(field_e s);
    return s inside {FS_UE_ID, FS_UE_CHROMA, FS_UE_W, FS_UE_H, FS_UE_L, FS_UE_R,
                     FS_UE_T, FS_UE_B};
  endfunction

  // Enter a field, falling through the ones that take no bits
  task automatic enter_field(field_e s);
    bit go;
    go = 1;
    while (go) begin
      go = 0;
      p_step = s;
      p_val = 0;
      p_gzc = 0;
      p_left = 0;
      case (s)
        FS_HDR:  p_left = 20;
        FS_SUBL: p_left = 3;
        FS_PTL:  p_left = 97;
        FS_FLAGS: begin
          if (p_nsub == 0) begin
            s = FS_UE_ID; go = 1;
          end else begin
            p_flags = 0;
            p_left = 2 * p_nsub;
          end
        end
        FS_RSVD: p_left = 2 * (8 - p_nsub);
        FS_SL_PROF: begin
          if (p_sidx >= p_nsub) begin
            s = FS_UE_ID; go = 1;
          end else if (p_flags[2*p_sidx]) begin
            p_left = 88;
          end else begin
            s = FS_SL_LVL; go = 1;
          end
        end
        FS_SL_LVL: begin
          if (p_flags[2*p_sidx+1]) begin
            p_left = 8;
          end else begin
            p_sidx++; s = FS_SL_PROF; go = 1;
          end
        end
        FS_SEP: begin
          if (p_chroma == 3) begin
            p_left = 1;
          end else begin
            s = FS_UE_W; go = 1;
          end
        end
        FS_WIN:  p_left = 1;
        FS_DONE: p_done = 1;
        default: ;
      endcase
    end
  endtask

  task automatic end_fixed();
    case (p_step)
      FS_HDR: enter_field(FS_SUBL);
      FS_SUBL: begin
        p_nsub = p_val & 7;
        if (p_nsub > MAX_SUB_LAYERS) p_err = hsps_pkg::STATUS_BAD_UE;
        else enter_field(FS_PTL);
      end
      FS_PTL:     enter_field(FS_FLAGS);
      FS_FLAGS:   enter_field(FS_RSVD);
      FS_RSVD: begin
        p_sidx = 0; enter_field(FS_SL_PROF);
      end
      FS_SL_PROF: enter_field(FS_SL_LVL);
      FS_SL_LVL: begin
        p_sidx++; enter_field(FS_SL_PROF);
      end
      FS_SEP:     enter_field(FS_UE_W);
      default:    enter_field(p_val != 0 ? FS_UE_L : FS_DONE);
    endcase
  endtask

  task automatic end_ue(logic [31:0] v);
    case (p_step)
      FS_UE_ID: enter_field(FS_UE_CHROMA);
      FS_UE_CHROMA: begin
        p_chroma = v; enter_field(FS_SEP);
      end
      FS_UE_W: begin
        p_coded[0] = v; enter_field(FS_UE_H);
      end
      FS_UE_H: begin
        p_coded[1] = v; enter_field(FS_WIN);
      end
      FS_UE_L: begin
        p_crop[0] = v; enter_field(FS_UE_R);
      end
      FS_UE_R: begin
        p_crop[0] = p_crop[0] + v; enter_field(FS_UE_T);
      end
      FS_UE_T: begin
        p_crop[1] = v; enter_field(FS_UE_B);
      end
      default: begin
        p_crop[1] = p_crop[1] + v; enter_field(FS_DONE);
      end
    endcase
  endtask

  task automatic walk_bit(bit b);
    logic [15:0] mark;
    logic [31:0] base;
    if (p_done || p_err != hsps_pkg::STATUS_OK) return;
    if (is_ue(p_step)) begin
      if (p_left == 0) begin
        if (!b) begin
          p_gzc++;
          if (p_gzc > 31) p_err = hsps_pkg::STATUS_BAD_UE;
        end else if (p_gzc == 0) begin
          end_ue(0);
        end else begin
          p_left = p_gzc;
          p_val = 0;
        end
        return;
      end
      p_val = {p_val[30:0], b};
      p_left--;
      if (p_left == 0) begin
        base = (32'd1 << p_gzc) - 32'd1;
        end_ue(base + p_val);
      end
      return;
    end
    if (p_step == FS_FLAGS && b) begin
      mark = 16'd1 << ((2 * p_nsub - p_left) & 15);
      p_flags = p_flags | mark[13:0];
    end
    p_val = {p_val[30:0], b};
    if (p_left > 0) p_left--;
    if (p_left == 0) end_fixed();
  endtask

  task automatic clear_parse();
    p_zrun = 0; p_nsub = 0; p_sidx = 0; p_flags = 0; p_chroma = 0;
    p_coded[0] = 0; p_coded[1] = 0; p_crop[0] = 0; p_crop[1] = 0;
    p_done = 0; p_err = hsps_pkg::STATUS_OK;
    enter_field(FS_HDR);
  endtask

  // Advance the model by one accepted item
  task automatic predict_size(logic [7:0] b, bit l);
    pic_size_t   r;
    logic [63:0] cw, ch, sw, sh;
    if (p_zrun >= 2 && b == 8'h03) begin
      p_zrun = 0;
    end else begin
      p_zrun = (b == 0) ? (p_zrun < 2 ? p_zrun + 1 : 2) : 0;
      for (int i = 7; i >= 0; i--) walk_bit(b[i]);
    end
    if (!l) return;
    r.width = 0;
    r.height = 0;
    if (p_err != hsps_pkg::STATUS_OK) begin
      r.status = p_err;
    end else if (!p_done) begin
      r.status = hsps_pkg::STATUS_RAN_OUT;
    end else begin
      sw = (p_chroma == 1 || p_chroma == 2) ? 2 : 1;
      sh = (p_chroma == 1) ? 2 : 1;
      cw = sw * {31'd0, p_crop[0]};
      ch = sh * {31'd0, p_crop[1]};
      if ({32'd0, p_coded[0]} <= cw || {32'd0, p_coded[1]} <= ch) begin
        r.status = hsps_pkg::STATUS_CROP;
      end else begin
        r.status = hsps_pkg::STATUS_OK;
        r.width = p_coded[0] - cw[31:0];
        r.height = p_coded[1] - ch[31:0];
      end
    end
    size_q.insert(size_q.size(), r);
    clear_parse();
  endtask

  // ---------------- driving ----------------
  task automatic send_byte(logic [7:0] b, bit l);
    int gap;
    bit acc;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_i <= l;
    do begin
      @(negedge clk);
      acc = !in_stall_o;
      @(posedge clk);
    end while (!acc);
    predict_size(b, l);
    bytes_sent++;
  endtask

  task automatic send_idle();
    in_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every pending result is out
  task automatic drain();
    send_idle();
    wait (size_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic put_rand(int n);
    for (int i = 0; i < n; i++) bit_q.insert(bit_q.size(), 1'($urandom_range(1)));
  endtask

  task automatic put_val(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) bit_q.insert(bit_q.size(), v[i]);
  endtask

  task automatic put_ue(logic [31:0] v);
    logic [32:0] x;
    int k;
    x = {1'b0, v} + 33'd1;
    k = 0;
    for (int i = 0; i < 33; i++) if (x[i]) k = i;
    repeat (k) bit_q.insert(bit_q.size(), 1'b0);
    for (int i = k; i >= 0; i--) bit_q.insert(bit_q.size(), x[i]);
  endtask

  // Lay out one SPS prefix; bad_ue puts an overlong prefix in place of the width
  task automatic build_sps(int nsub, logic [31:0] chroma, logic [31:0] w, logic [31:0] h,
                           bit win, logic [31:0] cl, logic [31:0] cr, logic [31:0] ct,
                           logic [31:0] cb, bit bad_ue);
    logic [13:0] fl;
    bit_q.delete();
    put_rand(20);
    put_val(nsub, 3);
    put_rand(97);
    if (nsub > 0) begin
      fl = 14'($urandom);
      for (int i = 0; i < 2 * nsub; i++) bit_q.insert(bit_q.size(), fl[i]);
      put_rand(2 * (8 - nsub));
      for (int i = 0; i < nsub; i++) begin
        if (fl[2*i]) put_rand(88);
        if (fl[2*i+1]) put_rand(8);
      end
    end
    put_ue($urandom_range(15));
    put_ue(chroma);
    if (chroma == 3) put_rand(1);
    if (bad_ue) begin
      repeat (32) bit_q.insert(bit_q.size(), 1'b0);
      put_rand(8);
    end else begin
      put_ue(w);
      put_ue(h);
      bit_q.insert(bit_q.size(), win);
      if (win) begin
        put_ue(cl); put_ue(cr); put_ue(ct); put_ue(cb);
      end
    end
    put_rand($urandom_range(12));
    while (bit_q.size() % 8 != 0) put_rand(1);
  endtask

  // Pack the bits, insert escapes, drop cut bytes from the tail, and send
  task automatic send_nal(int cut);
    logic [7:0] raw[$];
    logic [7:0] esc[$];
    logic [7:0] b;
    int zc;
    for (int i = 0; i < bit_q.size(); i += 8) begin
      for (int j = 0; j < 8; j++) b[7-j] = bit_q[i+j];
      raw.insert(raw.size(), b);
    end
    zc = 0;
    foreach (raw[i]) begin
      if (zc >= 2 && raw[i] <= 8'h03) begin
        esc.insert(esc.size(), 8'h03);
        zc = 0;
      end
      esc.insert(esc.size(), raw[i]);
      zc = (raw[i] == 0) ? zc + 1 : 0;
    end
    while (cut > 0 && esc.size() > 1) begin
      void'(esc.pop_back());
      cut--;
    end
    foreach (esc[i]) send_byte(esc[i], i == esc.size() - 1);
  endtask

  function automatic logic [31:0] rand_dim();
    return ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 4096);
  endfunction

  function automatic logic [31:0] rand_crop();
    return ($urandom_range(11) == 0) ? $urandom : $urandom_range(0, 12);
  endfunction

  // ---------------- checking ----------------
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(negedge clk) begin
    pic_size_t e;
    if (rst_n && out_valid_o && !out_stall_i) begin
      if (size_q.size() == 0) begin
        report("unexpected result", status_o, 0);
      end else begin
        e = size_q.pop_front();
        if (status_o !== e.status) report("status", status_o, e.status);
        if (pic_width_o !== e.width) report("pic_width", pic_width_o, e.width);
        if (pic_height_o !== e.height) report("pic_height", pic_height_o, e.height);
        sizes_seen++;
      end
    end
  end

  // Randomize the result stall
  always @(posedge clk) begin
    out_stall_i <= rst_n && ($urandom_range(99) < snk_stall_pct);
  end

  // Watchdog on cycles with no handshake on either side
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_short_units();
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    send_byte(8'h42, 0);
    send_byte(8'hA5, 1);
    send_idle();
  endtask

  task automatic test_escapes();
    // escape on the final byte, then a drop that clears the zero run
    send_byte(8'h00, 0);
    send_byte(8'h00, 0);
    send_byte(8'h03, 1);
    send_byte(8'h00, 0);
    send_byte(8'h00, 0);
    send_byte(8'h03, 0);
    send_byte(8'h00, 0);
    send_byte(8'h03, 1);
    send_idle();
  endtask

  task automatic test_chroma_formats();
    for (int c = 0; c < 4; c++) begin
      build_sps(c, c, 32'd64, 32'd48, 1, 1, 2, 1, 0, 0);
      send_nal(0);
    end
    send_idle();
  endtask

  task automatic test_corner_sizes();
    build_sps(MAX_SUB_LAYERS, 1, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1,
              32'hFFFF_FFFE, 32'hFFFF_FFFE, 0, 0, 0);
    send_nal(0);
    build_sps(0, 0, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0);
    send_nal(0);
    build_sps(0, 1, 32'd16, 32'd16, 1, 4, 4, 0, 0, 0);
    send_nal(0);
    build_sps(1, 1, 32'd16, 32'd16, 0, 0, 0, 0, 0, 1);
    send_nal(0);
    build_sps(2, 2, 32'd100, 32'd100, 1, 0, 0, 0, 0, 0);
    send_nal(3);
    drain();
  endtask

  task automatic test_random_units(int units);
    int kind;
    for (int u = 0; u < units; u++) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        int n;
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++) begin
          send_byte(($urandom_range(3) == 0) ? 8'h00 :
                    (($urandom_range(3) == 0) ? 8'h03 : 8'($urandom)), i == n - 1);
        end
      end else begin
        build_sps(($urandom_range(2) == 0) ? $urandom_range(MAX_SUB_LAYERS) :
                  $urandom_range(2),
                  ($urandom_range(15) == 0) ? $urandom : $urandom_range(3),
                  rand_dim(), rand_dim(), $urandom_range(1),
                  rand_crop(), rand_crop(), rand_crop(), rand_crop(),
                  kind < 18);
        send_nal((kind >= 18 && kind < 28) ? $urandom_range(1, 20) : 0);
      end
      if ($urandom_range(9) == 0) drain();
    end
    drain();
  endtask

  initial begin
    clear_parse();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_units();
    test_escapes();
    test_chroma_formats();
    test_corner_sizes();
    src_idle_pct = 0;  snk_stall_pct = 0;  test_random_units(5);
    src_idle_pct = 72; snk_stall_pct = 0;  test_random_units(5);
    src_idle_pct = 0;  snk_stall_pct = 72; test_random_units(5);
    src_idle_pct = 21; snk_stall_pct = 21; test_random_units(5);
    src_idle_pct = 0;  snk_stall_pct = 0;
    drain();
    repeat (64) @(posedge clk);
    if (errors == 0 && size_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
